// File: hdl/rbs_pkg.sv
// rbs_pkg: shared command and register codes, and constants for the
// retry backoff scheduler. No dependencies.
`default_nettype none

package rbs_pkg;

    // default fraction bits of the fixed-point growth factor
    localparam int FRAC_BITS_DEF = 16;

    // serial multiplier operand widths (LCG needs full 64 x 64)
    localparam int MUL_W = 64;
    // serial divider divisor width (2*span+1 stays below 2^26)
    localparam int DVS_W = 26;

    localparam int CFG_W = 64;
    localparam int IDX_W = 3;
    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_OPEN         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL_REQ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH_CANCEL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH_FAIL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POLL         = 3'd4;

    localparam logic [IDX_W-1:0] REG_BASE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX    = 3'd1;
    localparam logic [IDX_W-1:0] REG_GROWTH = 3'd2;
    localparam logic [IDX_W-1:0] REG_JITTER = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SEED   = 3'd5;

    localparam logic [23:0] DEF_BASE   = 24'd500;
    localparam logic [23:0] DEF_MAX    = 24'd30000;
    localparam logic [15:0] DEF_GROWTH = 16'd2000;
    localparam logic [6:0]  DEF_JITTER = 7'd20;
    localparam logic [7:0]  DEF_LIMIT  = 8'd8;

    localparam logic [DVS_W-1:0] GROWTH_DIV = 26'd1000;
    localparam logic [DVS_W-1:0] PCT_DIV    = 26'd100;

    localparam logic [MUL_W-1:0] LCG_MULT = 64'd6364136223846793005;
    localparam int RAND_LSB = 33;
    localparam int RAND_W   = 16;

endpackage

`default_nettype wire

// File: hdl/rbs_mul.sv
// rbs_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; widths come from the parent.
`default_nettype none

module rbs_mul #(
    parameter int A_W = 64,
    parameter int B_W = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic                    done,
    output logic [A_W+B_W-1:0]      product
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W+B_W-1:0] acc_reg;
    logic [A_W-1:0]     a_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [A_W:0]       sum;

    // upper half plus multiplicand when the low multiplier bit is set
    assign sum = {1'b0, acc_reg[A_W+B_W-1:B_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(B_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= {{A_W{1'b0}}, b};
            a_reg   <= a;
        end
        else if (run_reg)
        begin
            acc_reg <= {sum, acc_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: hdl/rbs_div.sv
// rbs_div: restoring divider, one quotient bit per cycle.
// Depends on nothing; widths come from the parent.
`default_nettype none

module rbs_div #(
    parameter int DVD_W = 40,
    parameter int DVS_W = 26
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DVS_W-1:0]   divisor,
    output logic                    done,
    output logic [DVD_W-1:0]        quotient,
    output logic [DVS_W-1:0]        remainder
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] r_reg;
    logic [DVS_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_reg, q_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            q_reg <= {q_reg[DVD_W-2:0], ge};
            r_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

// File: hdl/retry_backoff_scheduler.sv
// retry_backoff_scheduler: top level, command decode, scheduling sequencer
// and output word register. Uses rbs_pkg, rbs_mul and rbs_div.
`default_nettype none

// One input word gives one output word. Open, cancel request, fetch cancelled,
// fetch failed, a poll that is not due, a successful reconnect, an exhausted
// retry and the unused codes all go straight to the output state. A failed poll
// that schedules a retry runs a serial sequence on one bit-serial multiplier and
// one restoring divider: growth factor divide, then a step state and one multiply
// per growth step (up to attempt_count steps, fewer once the delay hits the ceiling),
// jitter span multiply and divide, LCG multiply and the jitter modulo. A new word
// is taken once the sequencer is back in idle, even while the previous output
// word still waits on out_stall. Config writes take effect on the next command
// only if the user writes config while the sequencer is idle; the block itself
// does not enforce this. The open command loads the seed into the generator.

module retry_backoff_scheduler #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [rbs_pkg::CMD_W-1:0]  command,
    input  wire logic [63:0]                now_ms,
    input  wire logic                       reconnect_ok,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            attempt_made,
    output logic                            reconnected,
    output logic                            retry_scheduled,
    output logic                            exhausted,
    output logic [24:0]                     delay_ms,
    output logic [63:0]                     deadline_ms,
    output logic [7:0]                      attempt_count,
    output logic                            reconnect_pending,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rbs_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [rbs_pkg::CFG_W-1:0]  cfg_data
);

    import rbs_pkg::*;

    // t holds the delay with FRAC_BITS fraction bits, m the growth factor
    localparam int T_W   = 24 + FRAC_BITS;
    localparam int M_W   = FRAC_BITS + 7;
    localparam int G_W   = 16 + FRAC_BITS;
    localparam int DVD_W = (G_W > 31) ? G_W : 31;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_OUT  = 4'd1;
    localparam logic [3:0] S_MDIV = 4'd2;
    localparam logic [3:0] S_GROW = 4'd3;
    localparam logic [3:0] S_GMUL = 4'd4;
    localparam logic [3:0] S_SMUL = 4'd5;
    localparam logic [3:0] S_SDIV = 4'd6;
    localparam logic [3:0] S_LCG  = 4'd7;
    localparam logic [3:0] S_RDIV = 4'd8;

    // config registers, raw; zero means default at use
    logic [23:0] base_reg, max_reg;
    logic [15:0] growth_reg;
    logic [6:0]  jitter_reg;
    logic [7:0]  limit_reg;
    logic [63:0] seed_reg;

    logic [23:0] base_eff, max_eff;
    logic [15:0] growth_eff;
    logic [6:0]  jitter_eff;
    logic [7:0]  limit_eff;

    // channel state
    logic        pending_reg, self_cancel_reg;
    logic [7:0]  attempts_reg;
    logic [63:0] deadline_reg;
    logic [63:0] lcg_reg;

    // sequencer
    logic [3:0]  state_reg, state_next;
    logic [63:0] now_reg;
    logic [M_W-1:0] m_reg;
    logic [T_W-1:0] t_reg;
    logic [7:0]  step_reg;
    logic [24:0] span_reg;
    logic        mul_go_reg, div_go_reg;

    // result word waiting for the output register
    logic        res_made_reg, res_recon_reg, res_sched_reg, res_exh_reg;
    logic [24:0] res_delay_reg;

    // output register
    logic        out_valid_reg;
    logic        o_made_reg, o_recon_reg, o_sched_reg, o_exh_reg, o_pend_reg;
    logic [24:0] o_delay_reg;
    logic [63:0] o_deadline_reg;
    logic [7:0]  o_count_reg;

    logic [MUL_W-1:0]       mul_a, mul_b;
    logic                   mul_done;
    logic [2*MUL_W-1:0]     mul_prod;
    logic [DVD_W-1:0]       div_dvd;
    logic [DVS_W-1:0]       div_dvs;
    logic                   div_done;
    logic [DVD_W-1:0]       div_q;
    logic [DVS_W-1:0]       div_r;

    logic           in_acc;
    logic           poll_due;
    logic           out_free;
    logic [23:0]    ms;
    logic [T_W-1:0] cap;
    logic [T_W+6:0] t_grown;
    logic [63:0]    lcg_step;
    logic [26:0]    jit_sum;
    logic [26:0]    jit_span;
    logic [26:0]    jit_delay;

    assign base_eff   = (base_reg   != '0) ? base_reg   : DEF_BASE;
    assign max_eff    = (max_reg    != '0) ? max_reg    : DEF_MAX;
    assign growth_eff = (growth_reg != '0) ? growth_reg : DEF_GROWTH;
    assign jitter_eff = (jitter_reg != '0) ? jitter_reg : DEF_JITTER;
    assign limit_eff  = (limit_reg  != '0) ? limit_reg  : DEF_LIMIT;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign poll_due = pending_reg && ((deadline_reg == '0) || (now_ms >= deadline_reg));

    // grown delay in whole ms, never above the ceiling
    assign ms       = (t_reg[T_W-1:FRAC_BITS] > max_eff) ? max_eff : t_reg[T_W-1:FRAC_BITS];
    assign cap      = {max_eff, {FRAC_BITS{1'b0}}};
    assign t_grown  = mul_prod[FRAC_BITS +: T_W+7];
    assign lcg_step = mul_prod[MUL_W-1:0] + 64'd1;

    // ms + (r mod (2*span+1)) - span, floored at zero
    assign jit_sum   = {3'b000, ms} + {1'b0, div_r};
    assign jit_span  = {2'b00, span_reg};
    assign jit_delay = (jit_sum < jit_span) ? '0 : (jit_sum - jit_span);

    // operand selection for the shared units
    always_comb
    begin
        unique case (state_reg)
            S_SMUL:
            begin
                mul_a = MUL_W'(ms);
                mul_b = MUL_W'(jitter_eff);
            end
            S_LCG:
            begin
                mul_a = lcg_reg;
                mul_b = LCG_MULT;
            end
            default:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(m_reg);
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_SDIV:
            begin
                div_dvd = DVD_W'(mul_prod[30:0]);
                div_dvs = PCT_DIV;
            end
            S_RDIV:
            begin
                div_dvd = DVD_W'(lcg_reg[RAND_LSB +: RAND_W]);
                div_dvs = {span_reg, 1'b1};
            end
            default:
            begin
                div_dvd = DVD_W'({growth_eff, {FRAC_BITS{1'b0}}});
                div_dvs = GROWTH_DIV;
            end
        endcase
    end

    rbs_mul #(
        .A_W(MUL_W),
        .B_W(MUL_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_go_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    rbs_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_go_reg),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if ((command == CMD_POLL) && poll_due && !reconnect_ok
                        && (attempts_reg < limit_eff))
                    begin
                        state_next = S_MDIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                state_next = (step_reg == attempts_reg) ? S_SMUL : S_GMUL;
            end
            S_GMUL:
            begin
                if (mul_done)
                begin
                    state_next = (t_grown >= (T_W+7)'(cap)) ? S_SMUL : S_GROW;
                end
            end
            S_SMUL:
            begin
                if (mul_done)
                begin
                    state_next = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    state_next = S_LCG;
                end
            end
            S_LCG:
            begin
                if (mul_done)
                begin
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, channel state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mul_go_reg      <= 1'b0;
            div_go_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            pending_reg     <= 1'b0;
            self_cancel_reg <= 1'b0;
            attempts_reg    <= '0;
            deadline_reg    <= '0;
            lcg_reg         <= '0;
            base_reg        <= DEF_BASE;
            max_reg         <= DEF_MAX;
            growth_reg      <= DEF_GROWTH;
            jitter_reg      <= DEF_JITTER;
            limit_reg       <= DEF_LIMIT;
            seed_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // kick a unit on entry to the state that uses it
            mul_go_reg <= (state_next != state_reg) && ((state_next == S_GMUL)
                          || (state_next == S_SMUL) || (state_next == S_LCG));
            div_go_reg <= (state_next != state_reg) && ((state_next == S_MDIV)
                          || (state_next == S_SDIV) || (state_next == S_RDIV));

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BASE:   base_reg   <= cfg_data[23:0];
                    REG_MAX:    max_reg    <= cfg_data[23:0];
                    REG_GROWTH: growth_reg <= cfg_data[15:0];
                    REG_JITTER: jitter_reg <= cfg_data[6:0];
                    REG_LIMIT:  limit_reg  <= cfg_data[7:0];
                    REG_SEED:   seed_reg   <= cfg_data;
                    default:    ;
                endcase
            end

            if (in_acc)
            begin
                unique case (command)
                    CMD_OPEN:
                    begin
                        pending_reg     <= 1'b0;
                        self_cancel_reg <= 1'b0;
                        attempts_reg    <= '0;
                        deadline_reg    <= '0;
                        lcg_reg         <= seed_reg;
                    end
                    CMD_CANCEL_REQ:
                    begin
                        self_cancel_reg <= 1'b1;
                    end
                    CMD_FETCH_CANCEL:
                    begin
                        if (self_cancel_reg)
                        begin
                            self_cancel_reg <= 1'b0;
                        end
                        else
                        begin
                            pending_reg <= 1'b1;
                        end
                    end
                    CMD_FETCH_FAIL:
                    begin
                        pending_reg <= 1'b1;
                    end
                    CMD_POLL:
                    begin
                        if (poll_due)
                        begin
                            priority if (reconnect_ok)
                            begin
                                pending_reg  <= 1'b0;
                                attempts_reg <= '0;
                                deadline_reg <= '0;
                            end
                            else if (attempts_reg < limit_eff)
                            begin
                                attempts_reg <= attempts_reg + 8'd1;
                            end
                            else
                            begin
                                pending_reg <= 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if ((state_reg == S_LCG) && mul_done)
            begin
                lcg_reg <= lcg_step;
            end
            if ((state_reg == S_RDIV) && div_done)
            begin
                deadline_reg <= now_reg + 64'(jit_delay[24:0]);
            end

            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and result words
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            now_reg       <= now_ms;
            res_delay_reg <= '0;
            res_sched_reg <= 1'b0;
            res_made_reg  <= (command == CMD_POLL) && poll_due;
            res_recon_reg <= (command == CMD_POLL) && poll_due && reconnect_ok;
            res_exh_reg   <= (command == CMD_POLL) && poll_due && !reconnect_ok
                             && (attempts_reg >= limit_eff);
        end

        if ((state_reg == S_MDIV) && div_done)
        begin
            m_reg    <= div_q[M_W-1:0];
            t_reg    <= {base_eff, {FRAC_BITS{1'b0}}};
            step_reg <= '0;
        end

        if ((state_reg == S_GMUL) && mul_done)
        begin
            step_reg <= step_reg + 8'd1;
            if (t_grown >= (T_W+7)'(cap))
            begin
                t_reg <= cap;
            end
            else
            begin
                t_reg <= t_grown[T_W-1:0];
            end
        end

        if ((state_reg == S_SDIV) && div_done)
        begin
            span_reg <= div_q[24:0];
        end

        if ((state_reg == S_RDIV) && div_done)
        begin
            res_delay_reg <= jit_delay[24:0];
            res_sched_reg <= 1'b1;
        end

        if ((state_reg == S_OUT) && out_free)
        begin
            o_made_reg     <= res_made_reg;
            o_recon_reg    <= res_recon_reg;
            o_sched_reg    <= res_sched_reg;
            o_exh_reg      <= res_exh_reg;
            o_delay_reg    <= res_delay_reg;
            o_deadline_reg <= deadline_reg;
            o_count_reg    <= attempts_reg;
            o_pend_reg     <= pending_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign attempt_made      = o_made_reg;
    assign reconnected       = o_recon_reg;
    assign retry_scheduled   = o_sched_reg;
    assign exhausted         = o_exh_reg;
    assign delay_ms          = o_delay_reg;
    assign deadline_ms       = o_deadline_reg;
    assign attempt_count     = o_count_reg;
    assign reconnect_pending = o_pend_reg;

endmodule

`default_nettype wire

// File: sim/retry_backoff_scheduler_checker.sv
// retry_backoff_scheduler_checker: watches the input, output and config ports,
// predicts each status word and compares it field by field. Depends on rbs_pkg.
module retry_backoff_scheduler_checker
    import rbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [63:0]           now_ms,
    input  logic                  reconnect_ok,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  attempt_made,
    input  logic                  reconnected,
    input  logic                  retry_scheduled,
    input  logic                  exhausted,
    input  logic [24:0]           delay_ms,
    input  logic [63:0]           deadline_ms,
    input  logic [7:0]            attempt_count,
    input  logic                  reconnect_pending,
    input  logic                  cfg_wr_en,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic        made;
        logic        recon;
        logic        sched;
        logic        exh;
        logic [24:0] delay;
        logic [63:0] deadline;
        logic [7:0]  tries;
        logic        pending;
    } status_t;

    status_t status_q[$];

    logic [23:0] base_reg, max_reg;
    logic [15:0] growth_reg;
    logic [6:0]  jitter_reg;
    logic [7:0]  limit_reg;
    logic [63:0] seed_reg;

    logic        pend, self_cancel;
    logic [7:0]  tries;
    logic [63:0] due, lcg;

    function automatic logic [63:0] jittered_delay(logic [7:0] steps);
        logic [63:0] base, maxd, grow, pct, m, cap, t, ms, span, r, dpos;
        logic [63:0] fmask;
        int i;
        base  = (base_reg != 0) ? 64'(base_reg) : 64'(DEF_BASE);
        maxd  = (max_reg != 0) ? 64'(max_reg) : 64'(DEF_MAX);
        grow  = (growth_reg != 0) ? 64'(growth_reg) : 64'(DEF_GROWTH);
        pct   = (jitter_reg != 0) ? 64'(jitter_reg) : 64'(DEF_JITTER);
        fmask = (64'd1 << FRAC) - 1;
        m     = (grow << FRAC) / 64'(GROWTH_DIV);
        cap   = maxd << FRAC;
        t     = base << FRAC;
        for (i = 0; i < steps; i++)
        begin
            t = (t >> FRAC) * m + (((t & fmask) * m) >> FRAC);
            if (t >= cap)
            begin
                t = cap;
                break;
            end
        end
        ms = t >> FRAC;
        if (ms > maxd)
            ms = maxd;
        span = (ms * pct) / 64'(PCT_DIV);
        lcg  = lcg * LCG_MULT + 64'd1;
        r    = (lcg >> RAND_LSB) & ((64'd1 << RAND_W) - 1);
        dpos = r % (2 * span + 1);
        if (ms + dpos < span)
            return 64'd0;
        return ms + dpos - span;
    endfunction

    // one command in, one status word out
    function automatic status_t schedule_step(logic [CMD_W-1:0] cmd, logic [63:0] now,
                                              logic ok);
        status_t s;
        logic [7:0] lim;
        logic [63:0] d;
        s   = '0;
        lim = (limit_reg != 0) ? limit_reg : DEF_LIMIT;
        case (cmd)
            CMD_OPEN:
            begin
                pend = 0; self_cancel = 0; tries = 0; due = 0; lcg = seed_reg;
            end
            CMD_CANCEL_REQ:   self_cancel = 1;
            CMD_FETCH_CANCEL:
            begin
                if (self_cancel)
                    self_cancel = 0;
                else
                    pend = 1;
            end
            CMD_FETCH_FAIL:   pend = 1;
            CMD_POLL:
            begin
                if (pend && (due == 0 || now >= due))
                begin
                    s.made = 1;
                    if (ok)
                    begin
                        s.recon = 1; pend = 0; tries = 0; due = 0;
                    end
                    else if (tries < lim)
                    begin
                        tries   = tries + 8'd1;
                        d       = jittered_delay(tries);
                        s.delay = d[24:0];
                        due     = now + d;
                        s.sched = 1;
                    end
                    else
                    begin
                        s.exh = 1;
                        pend  = 0;
                    end
                end
            end
            default: ;
        endcase
        s.deadline = due;
        s.tries    = tries;
        s.pending  = pend;
        return s;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            base_reg = DEF_BASE; max_reg = DEF_MAX; growth_reg = DEF_GROWTH;
            jitter_reg = DEF_JITTER; limit_reg = DEF_LIMIT; seed_reg = '0;
            pend = 0; self_cancel = 0; tries = 0; due = 0; lcg = 0;
            status_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BASE:   base_reg   = cfg_data[23:0];
                    REG_MAX:    max_reg    = cfg_data[23:0];
                    REG_GROWTH: growth_reg = cfg_data[15:0];
                    REG_JITTER: jitter_reg = cfg_data[6:0];
                    REG_LIMIT:  limit_reg  = cfg_data[7:0];
                    REG_SEED:   seed_reg   = cfg_data;
                    default: ;
                endcase
            end
            // results leave before the new word's prediction goes in
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: status word with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (attempt_made !== want.made)
                        report_mismatch("attempt_made", attempt_made, want.made);
                    if (reconnected !== want.recon)
                        report_mismatch("reconnected", reconnected, want.recon);
                    if (retry_scheduled !== want.sched)
                        report_mismatch("retry_scheduled", retry_scheduled, want.sched);
                    if (exhausted !== want.exh)
                        report_mismatch("exhausted", exhausted, want.exh);
                    if (delay_ms !== want.delay)
                        report_mismatch("delay_ms", delay_ms, want.delay);
                    if (deadline_ms !== want.deadline)
                        report_mismatch("deadline_ms", deadline_ms, want.deadline);
                    if (attempt_count !== want.tries)
                        report_mismatch("attempt_count", attempt_count, want.tries);
                    if (reconnect_pending !== want.pending)
                        report_mismatch("reconnect_pending", reconnect_pending, want.pending);
                end
            end
            if (in_valid && !in_stall)
                status_q.push_back(schedule_step(command, now_ms, reconnect_ok));
            outstanding = status_q.size();
        end
    end

    final
    begin
    end
endmodule

// File: sim/retry_backoff_scheduler_tb.sv
// retry_backoff_scheduler_tb: drives commands and config writes into the
// scheduler and gives the verdict. Depends on rbs_pkg, the DUT and the checker.
module retry_backoff_scheduler_tb;
    import rbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // no word moving for this many cycles means the block hung; the limit covers
    // the slowest retry (255 growth steps)
    localparam int IDLE_LIMIT = 120000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CMD_W-1:0]  command;
    logic [63:0]       now_ms;
    logic              reconnect_ok;
    logic              out_valid;
    logic              out_stall;
    logic              attempt_made, reconnected, retry_scheduled, exhausted;
    logic [24:0]       delay_ms;
    logic [63:0]       deadline_ms;
    logic [7:0]        attempt_count;
    logic              reconnect_pending;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int                fail_count;
    int                outstanding;
    int                quiet_cycles;
    bit                calm;       // no idling on either side while set
    logic [63:0]       sim_ms;     // running millisecond clock for well-formed polls

    retry_backoff_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .now_ms(now_ms), .reconnect_ok(reconnect_ok),
        .out_valid(out_valid), .out_stall(out_stall),
        .attempt_made(attempt_made), .reconnected(reconnected),
        .retry_scheduled(retry_scheduled), .exhausted(exhausted),
        .delay_ms(delay_ms), .deadline_ms(deadline_ms),
        .attempt_count(attempt_count), .reconnect_pending(reconnect_pending),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    retry_backoff_scheduler_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .now_ms(now_ms), .reconnect_ok(reconnect_ok),
        .out_valid(out_valid), .out_stall(out_stall),
        .attempt_made(attempt_made), .reconnected(reconnected),
        .retry_scheduled(retry_scheduled), .exhausted(exhausted),
        .delay_ms(delay_ms), .deadline_ms(deadline_ms),
        .attempt_count(attempt_count), .reconnect_pending(reconnect_pending),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always #6 clk = ~clk;

    // receiver stalls about 28% of cycles outside the calm stretch
    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);

    // watchdog: counts cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("retry_backoff_scheduler_tb failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // register value biased toward zero (default) and all ones
    function automatic logic [63:0] pick_value(logic [63:0] top);
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return 64'd0;
        if (roll < 30)
            return top;
        return rand64() % (top + 64'd1);
    endfunction

    // one command word; optional idle gap before it, holds until accepted
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [63:0] now, logic ok);
        if (!calm && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        now_ms       <= now;
        reconnect_ok <= ok;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // a poll at a clock that has moved on, usually far enough to be due
    task automatic send_poll(logic ok);
        if ($urandom_range(99) < 30)
            sim_ms = sim_ms + $urandom_range(0, 1000);
        else
            sim_ms = sim_ms + $urandom_range(0, 40000000);
        send_word(CMD_POLL, sim_ms, ok);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // stop sending and wait until every expected word has come out; the extra
    // edge lets the checker count a word accepted at the edge just passed
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    // all six registers, written only once the block has drained
    task automatic configure(logic [63:0] base, logic [63:0] maxd, logic [63:0] grow,
                             logic [63:0] jit, logic [63:0] lim, logic [63:0] seed);
        drain();
        repeat (20) @(posedge clk);
        write_reg(REG_BASE, base);
        write_reg(REG_MAX, maxd);
        write_reg(REG_GROWTH, grow);
        write_reg(REG_JITTER, jit);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_SEED, seed);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] grow, lim;
        int phase, n, k;
        clk = 0; rst_n = 0; calm = 0; sim_ms = 0; quiet_cycles = 0;
        in_valid = 0; command = CMD_OPEN; now_ms = 0; reconnect_ok = 0;
        out_stall = 0; cfg_wr_en = 0; cfg_index = REG_BASE; cfg_data = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults except a retry limit of two, all-ones seed
        configure(0, 0, 0, 0, 2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_OPEN, 0, 0);
        send_word(CMD_POLL, 0, 0);                       // nothing pending
        send_word(CMD_CANCEL_REQ, 0, 0);
        send_word(CMD_FETCH_CANCEL, 0, 0);               // own cancel, swallowed
        send_word(CMD_FETCH_CANCEL, 0, 0);               // foreign cancel, pending
        send_word(CMD_POLL, 0, 0);                       // zero deadline, due
        send_word(CMD_POLL, 1, 1);                       // not yet due
        send_word(CMD_POLL, 64'd100000, 0);              // second retry
        send_word(CMD_POLL, 64'd200000, 0);              // limit reached
        send_word(CMD_FETCH_FAIL, 0, 0);
        send_word(CMD_POLL, 64'd300000, 1);              // reconnect clears state
        send_word(CMD_FETCH_FAIL, 0, 0);
        send_word(CMD_POLL, 64'hFFFF_FFFF_FFFF_FF00, 0); // deadline wraps
        send_word(CMD_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        send_word(3'd5, rand64(), 1);                    // unused codes
        send_word(3'd6, rand64(), 0);
        send_word(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        send_word(CMD_OPEN, 0, 0);

        // extremes: largest base, max, growth and over-range jitter
        configure(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 7'h7F, 3, 0);
        send_word(CMD_OPEN, 0, 0);
        send_word(CMD_FETCH_FAIL, 0, 0);
        send_word(CMD_POLL, 64'd5, 0);
        send_word(CMD_POLL, 64'd90000000, 0);
        send_word(CMD_POLL, 64'd190000000, 0);

        for (phase = 0; phase < 13; phase++)
        begin
            grow = pick_value(16'hFFFF);
            lim  = pick_value(8'hFF);
            // growth at or under 1x never reaches the ceiling: keep step counts low
            if (grow != 0 && grow <= 1000)
                lim = $urandom_range(1, 12);
            if (phase == 1)
                lim = 8'hFF;
            configure(pick_value(24'hFFFFFF), pick_value(24'hFFFFFF), grow,
                      pick_value(7'h7F), lim, rand64());
            calm   = (phase == 7);
            sim_ms = rand64() >> $urandom_range(8, 40);
            send_word(CMD_OPEN, 0, 0);
            n = 0;
            while (n < 150)
            begin
                if (phase == 5 && n == 60)
                begin
                    // hold the sender until the block has fully drained
                    drain();
                    @(posedge clk);
                end
                if ($urandom_range(99) < 80)
                begin
                    case ($urandom_range(2))
                        0: send_word(CMD_FETCH_FAIL, rand64(), $urandom_range(1));
                        1: send_word(CMD_FETCH_CANCEL, rand64(), $urandom_range(1));
                        default:
                        begin
                            send_word(CMD_CANCEL_REQ, rand64(), $urandom_range(1));
                            send_word(CMD_FETCH_CANCEL, rand64(), $urandom_range(1));
                            n++;
                        end
                    endcase
                    n++;
                    for (k = $urandom_range(1, 6); k > 0; k--)
                    begin
                        send_poll($urandom_range(99) < 15);
                        n++;
                    end
                end
                else
                begin
                    if ($urandom_range(99) < 20)
                        send_word(CMD_OPEN, rand64(), $urandom_range(1));
                    else if ($urandom_range(1))
                        send_word(3'($urandom_range(7)), rand64(), $urandom_range(1));
                    else
                        send_word(3'($urandom_range(7)), sim_ms + $urandom_range(0, 50000),
                                  $urandom_range(1));
                    n++;
                end
            end
        end
        calm = 0;

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("retry_backoff_scheduler_tb passed");
        else
            $display("retry_backoff_scheduler_tb failed");
        $finish;
    end
endmodule
